/* rtl/lcr_pkg.sv */
`timescale 1ns / 1ps

package lcr_pkg;

    // link mode, one-hot
    typedef enum logic [4:0] {
        MODE_DISC   = 5'b00001,
        MODE_CONN   = 5'b00010,
        MODE_RECONN = 5'b00100,
        MODE_UP     = 5'b01000,
        MODE_FAIL   = 5'b10000
    } t_mode;

    // reported mode codes
    localparam logic [2:0] CODE_DISC   = 3'd0;
    localparam logic [2:0] CODE_CONN   = 3'd1;
    localparam logic [2:0] CODE_RECONN = 3'd2;
    localparam logic [2:0] CODE_UP     = 3'd3;
    localparam logic [2:0] CODE_FAIL   = 3'd4;

    // register map, word index
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_WAIT    = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    // register reset values
    localparam logic [31:0] TIMEOUT_RST = 32'd10000;
    localparam logic [31:0] WAIT_RST    = 32'd5000;
    localparam logic [7:0]  LIMIT_RST   = 8'd5;

    localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0]  RETRY_MAX   = 8'hFF;

    // stream widths
    localparam int unsigned IN_W  = 48;
    localparam int unsigned OUT_W = 56;

    typedef struct packed {
        logic [31:0] connect_timeout_ms;
        logic [31:0] reconnect_wait_ms;
        logic [7:0]  retry_limit;
    } t_cfg;

    typedef struct packed {
        logic               link_up;
        logic               tick;
        logic               want_connect;
        logic               want_disconnect;
        logic signed [7:0]  signal_dbm;
        logic [31:0]        link_address;
    } t_item;

    typedef struct packed {
        logic [2:0]         mode;
        logic               is_connected;
        logic [7:0]         retries;
        logic signed [7:0]  report_dbm;
        logic [31:0]        report_address;
        logic               begin_pulse;
        logic               drop_pulse;
    } t_result;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_DISC:   c = CODE_DISC;
            MODE_CONN:   c = CODE_CONN;
            MODE_RECONN: c = CODE_RECONN;
            MODE_UP:     c = CODE_UP;
            MODE_FAIL:   c = CODE_FAIL;
            default:     c = CODE_DISC;
        endcase
        return c;
    endfunction

endpackage

/* rtl/link_connect_retry_fsm.sv */
`timescale 1ns / 1ps

// Link connect and retry controller. Each input word is one pass of the control
// loop; the block answers with one status word per input word, in order. Input
// words are registered, then one pass of mode, elapsed-time and retry logic
// runs into an output register, so a word can be taken every cycle while the
// output side does not stall, and its status word is held in the output register
// until the output side is ready. The loop through the mode, elapsed and retry
// registers sets that rate. Registers are written through the APB port at 0x0
// (connect timeout), 0x4 (reconnect wait) and 0x8 (retry limit); the user must
// write them only while no word is in flight, as the block does not enforce it.
module link_connect_retry_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input words
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // link_up, tick, want_connect, want_disconnect, signal_dbm[7:0],
    // link_address[31:0], zero pad
    input  logic [lcr_pkg::IN_W-1:0]    s_axis_tdata,
    // status words
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // mode[2:0], is_connected, retries[7:0], report_dbm[7:0],
    // report_address[31:0], begin_pulse, drop_pulse, zero pad
    output logic [lcr_pkg::OUT_W-1:0]   m_axis_tdata
);
    import lcr_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result res;
    logic    item_valid;
    logic    out_free;
    logic    step;
    logic    r_out_valid;
    t_result r_out;

    lcr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_advance (out_free),
        .o_ready   (s_axis_tready),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    // a word moves to the output register when that register is free
    assign out_free = ~r_out_valid | m_axis_tready;
    assign step     = item_valid & out_free;

    lcr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.drop_pulse, r_out.begin_pulse,
                            r_out.report_address, r_out.report_dbm, r_out.retries,
                            r_out.is_connected, r_out.mode};

endmodule

/* rtl/lcr_cfg.sv */
`timescale 1ns / 1ps

module lcr_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lcr_pkg::t_cfg              o_cfg
);
    import lcr_pkg::*;

    logic [31:0] r_timeout;
    logic [31:0] r_wait;
    logic [7:0]  r_limit;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_wait    <= WAIT_RST;
            r_limit   <= LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TIMEOUT: r_timeout <= pwdata;
                REG_WAIT:    r_wait    <= pwdata;
                REG_LIMIT:   r_limit   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_TIMEOUT: prdata = r_timeout;
            REG_WAIT:    prdata = r_wait;
            REG_LIMIT:   prdata = {24'd0, r_limit};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.connect_timeout_ms = r_timeout;
    assign o_cfg.reconnect_wait_ms  = r_wait;
    assign o_cfg.retry_limit        = r_limit;

endmodule

/* rtl/lcr_in_stage.sv */
`timescale 1ns / 1ps

module lcr_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lcr_pkg::IN_W-1:0]  i_data,
    input  logic                      i_advance,
    output logic                      o_ready,
    output logic                      o_valid,
    output lcr_pkg::t_item            o_item
);
    import lcr_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item in_item;

    // unpack stream word
    assign in_item.link_up         = i_data[0];
    assign in_item.tick            = i_data[1];
    assign in_item.want_connect    = i_data[2];
    assign in_item.want_disconnect = i_data[3];
    assign in_item.signal_dbm      = i_data[11:4];
    assign in_item.link_address    = i_data[43:12];

    // free when empty or when the held word moves on this cycle
    assign o_ready = ~r_valid | i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/lcr_core.sv */
`timescale 1ns / 1ps

module lcr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  lcr_pkg::t_item   i_item,
    input  lcr_pkg::t_cfg    i_cfg,
    output lcr_pkg::t_result o_res
);
    import lcr_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [31:0] r_elapsed;
    logic [31:0] n_elapsed;
    logic [7:0]  r_retry;
    logic [7:0]  n_retry;

    // one control pass: tick, monitoring, wait, sample, requests
    always_comb begin
        t_mode       m;
        logic [31:0] el;
        logic [7:0]  rc;
        logic        b;
        logic        d;
        logic        conn;

        m  = r_mode;
        el = r_elapsed;
        rc = r_retry;
        b  = 1'b0;
        d  = 1'b0;

        // saturating millisecond count
        if (i_item.tick && el != ELAPSED_MAX) begin
            el = el + 32'd1;
        end

        // link monitoring
        case (m)
            MODE_CONN, MODE_RECONN: begin
                if (i_item.link_up) begin
                    m  = MODE_UP;
                    rc = '0;
                end else if (el >= i_cfg.connect_timeout_ms) begin
                    d = 1'b1;
                    if (rc != RETRY_MAX) begin
                        rc = rc + 8'd1;
                    end
                    if (i_cfg.retry_limit != 8'd0 && rc >= i_cfg.retry_limit) begin
                        m = MODE_FAIL;
                    end else begin
                        m  = MODE_RECONN;
                        el = '0;
                    end
                end
            end
            MODE_UP: begin
                if (!i_item.link_up) begin
                    m  = MODE_RECONN;
                    el = '0;
                end
            end
            default: ;
        endcase

        // wait over, start a new attempt
        if (m == MODE_RECONN && !i_item.link_up && el >= i_cfg.reconnect_wait_ms) begin
            b  = 1'b1;
            m  = MODE_CONN;
            el = '0;
        end

        // status is taken here, before the requests
        conn                 = (m == MODE_UP);
        o_res.mode           = mode_code(m);
        o_res.is_connected   = conn;
        o_res.retries        = rc;
        o_res.report_dbm     = conn ? i_item.signal_dbm : 8'sd0;
        o_res.report_address = conn ? i_item.link_address : 32'd0;

        // connect request only from idle or failed
        if (i_item.want_connect && (m == MODE_DISC || m == MODE_FAIL)) begin
            rc = '0;
            b  = 1'b1;
            m  = MODE_CONN;
            el = '0;
        end

        // disconnect request wins, elapsed count kept
        if (i_item.want_disconnect) begin
            d  = 1'b1;
            m  = MODE_DISC;
            rc = '0;
        end

        o_res.begin_pulse = b;
        o_res.drop_pulse  = d;
        n_mode            = m;
        n_elapsed         = el;
        n_retry           = rc;
    end

    // state update, one pass per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DISC;
            r_elapsed <= '0;
            r_retry   <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_retry   <= n_retry;
        end
    end

    // disconnect request always lands in idle with the count cleared
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.want_disconnect |=> r_mode == MODE_DISC && r_retry == 8'd0)
        else $error("disconnect request did not reach idle");

    // a begin leaves the block connecting unless a disconnect followed
    a_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.begin_pulse |=> r_mode == MODE_CONN || r_mode == MODE_DISC)
        else $error("begin issued without entering connecting");

    // connected status never carries a timeout count
    a_conn_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.is_connected |-> o_res.retries == 8'd0)
        else $error("connected with nonzero retry count");

    // state holds between words
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_elapsed) && $stable(r_retry))
        else $error("state moved without a word");

endmodule

/* dv/tb_link_connect_retry_fsm.sv */
`timescale 1ns / 1ps

module tb_link_connect_retry_fsm;

    import lcr_pkg::*;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // input words
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // link_up, tick, want_connect, want_disconnect, signal_dbm[7:0],
    // link_address[31:0], zero pad
    logic [IN_W-1:0]     s_axis_tdata  = '0;

    // status words
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // mode[2:0], is_connected, retries[7:0], report_dbm[7:0],
    // report_address[31:0], begin_pulse, drop_pulse, zero pad
    logic [OUT_W-1:0]    m_axis_tdata;

    link_connect_retry_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // predictor state and register copy
    t_cfg        cfg_q       = '{connect_timeout_ms: TIMEOUT_RST,
                                 reconnect_wait_ms:  WAIT_RST,
                                 retry_limit:        LIMIT_RST};
    logic [2:0]  link_mode_q = CODE_DISC;
    logic [31:0] elapsed_q   = '0;
    logic [7:0]  retries_q   = '0;

    // expected status words, oldest first
    t_result     status_q[$];

    // run control and counters
    bit          idle_on     = 1'b1;
    int          hold_left   = 0;
    int          stall_left  = 0;
    int          n_fail      = 0;
    int          n_passes    = 0;
    int          n_status    = 0;
    int          n_settings  = 0;

    // link level runs for the traffic generator
    bit          level_q     = 1'b0;
    int          run_left    = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("status word %0d: %s got 0x%0h, expected 0x%0h",
                 n_status, what, got, want);
        n_fail++;
    endtask

    // one pass of the control loop, as the block should compute it
    task automatic advance_link(input t_item it, output t_result r);
        logic begin_p;
        logic drop_p;
        logic conn;
        begin_p = 1'b0;
        drop_p  = 1'b0;

        if (it.tick && elapsed_q != ELAPSED_MAX)
            elapsed_q++;

        // link monitoring
        case (link_mode_q)
            CODE_CONN, CODE_RECONN: begin
                if (it.link_up) begin
                    link_mode_q = CODE_UP;
                    retries_q   = '0;
                end else if (elapsed_q >= cfg_q.connect_timeout_ms) begin
                    drop_p = 1'b1;
                    if (retries_q != RETRY_MAX)
                        retries_q++;
                    if (cfg_q.retry_limit != 0 && retries_q >= cfg_q.retry_limit) begin
                        link_mode_q = CODE_FAIL;
                    end else begin
                        link_mode_q = CODE_RECONN;
                        elapsed_q   = '0;
                    end
                end
            end
            CODE_UP: begin
                if (!it.link_up) begin
                    link_mode_q = CODE_RECONN;
                    elapsed_q   = '0;
                end
            end
            default: ;
        endcase

        // reconnect wait over: new attempt
        if (link_mode_q == CODE_RECONN && !it.link_up
                && elapsed_q >= cfg_q.reconnect_wait_ms) begin
            begin_p     = 1'b1;
            link_mode_q = CODE_CONN;
            elapsed_q   = '0;
        end

        // status is taken before the requests
        conn             = (link_mode_q == CODE_UP);
        r.mode           = link_mode_q;
        r.is_connected   = conn;
        r.retries        = retries_q;
        r.report_dbm     = conn ? it.signal_dbm : 8'sd0;
        r.report_address = conn ? it.link_address : 32'd0;

        if (it.want_connect && (link_mode_q == CODE_DISC || link_mode_q == CODE_FAIL)) begin
            retries_q   = '0;
            begin_p     = 1'b1;
            link_mode_q = CODE_CONN;
            elapsed_q   = '0;
        end
        if (it.want_disconnect) begin
            drop_p      = 1'b1;
            link_mode_q = CODE_DISC;
            retries_q   = '0;
        end

        r.begin_pulse = begin_p;
        r.drop_pulse  = drop_p;
    endtask

    function automatic t_item mk(input bit up, input bit tick, input bit wc,
                                 input bit wd, input logic [7:0] dbm,
                                 input logic [31:0] addr);
        t_item it;
        it.link_up         = up;
        it.tick            = tick;
        it.want_connect    = wc;
        it.want_disconnect = wd;
        it.signal_dbm      = dbm;
        it.link_address    = addr;
        return it;
    endfunction

    // offer one word and wait until it is taken
    task automatic send_pass(input t_item it);
        int      gap;
        t_result r;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.link_address, it.signal_dbm, it.want_disconnect,
                          it.want_connect, it.tick, it.link_up};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_link(it, r);
        status_q.push_back(r);
        n_passes++;
    endtask

    // stop offering and wait for every outstanding status word
    task automatic drain_status;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (status_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_TIMEOUT: begin
                cfg_q.connect_timeout_ms = value;
                want = value;
            end
            REG_WAIT: begin
                cfg_q.reconnect_wait_ms = value;
                want = value;
            end
            default: begin
                cfg_q.retry_limit = value[7:0];
                want = {24'd0, value[7:0]};
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("read back of register %0d", idx), prdata, want);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_registers(input logic [31:0] timeout, input logic [31:0] wait_ms,
                                 input logic [7:0] limit);
        drain_status();
        write_register(REG_TIMEOUT, timeout);
        write_register(REG_WAIT, wait_ms);
        write_register(REG_LIMIT, {24'd0, limit});
        n_settings++;
    endtask

    // link level held in runs, requests now and then, some fully random words
    task automatic drive_traffic(input int n_items, input int noise_pct);
        t_item it;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                it = mk(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                        8'($urandom), $urandom);
            end else begin
                if (run_left == 0) begin
                    level_q  = 1'($urandom_range(0, 1));
                    run_left = $urandom_range(1, 25);
                end
                run_left--;
                it = mk(level_q, $urandom_range(0, 9) < 7, $urandom_range(0, 11) == 0,
                        $urandom_range(0, 29) == 0, 8'($urandom), $urandom);
            end
            send_pass(it);
        end
    endtask

    // walk through every mode with short timers
    task automatic test_connect_sequence;
        set_registers(32'd2, 32'd1, 8'd2);
        send_pass(mk(0, 0, 0, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 1, 0, 0, 8'h80, 32'h0000_0000));
        send_pass(mk(0, 0, 1, 0, 8'h7F, 32'hFFFF_FFFF));
        // connect while connecting is ignored
        send_pass(mk(0, 1, 1, 0, 8'h01, 32'h1234_5678));
        send_pass(mk(0, 1, 0, 0, 8'hFF, 32'h8765_4321));
        // connect while reconnecting is ignored
        send_pass(mk(0, 1, 1, 0, 8'h00, 32'h0000_0001));
        send_pass(mk(0, 1, 0, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 1, 0, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 1, 0, 0, 8'h00, 32'h0000_0000));
        // link up in failed takes no action
        send_pass(mk(1, 0, 0, 0, 8'h10, 32'hDEAD_BEEF));
        send_pass(mk(0, 0, 1, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(1, 0, 0, 0, 8'h80, 32'hFFFF_FFFF));
        // connect while connected is ignored
        send_pass(mk(1, 1, 1, 0, 8'h7F, 32'h0000_0000));
        send_pass(mk(1, 0, 0, 0, 8'h55, 32'hAAAA_5555));
        // link loss and recovery
        send_pass(mk(0, 0, 0, 0, 8'hAA, 32'h5555_AAAA));
        send_pass(mk(1, 0, 0, 0, 8'hC0, 32'h0F0F_0F0F));
        send_pass(mk(1, 0, 0, 1, 8'h3C, 32'hF0F0_F0F0));
        // both requests in one word
        send_pass(mk(0, 0, 1, 1, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 0, 0, 1, 8'h00, 32'h0000_0000));
    endtask

    // zero wait: new attempt issued in the same step as the loss or timeout
    task automatic test_zero_wait;
        set_registers(32'd1, 32'd0, 8'd0);
        send_pass(mk(0, 0, 1, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(1, 0, 0, 0, 8'h9C, 32'hC0A8_0001));
        send_pass(mk(0, 0, 0, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 1, 0, 0, 8'h00, 32'h0000_0000));
        send_pass(mk(0, 0, 0, 1, 8'h00, 32'h0000_0000));
    endtask

    // endless retry with immediate timeout drives the retry count to its ceiling
    task automatic test_retry_saturation;
        set_registers(32'd0, 32'd0, 8'd0);
        send_pass(mk(0, 0, 1, 0, 8'($urandom), $urandom));
        for (int k = 0; k < 270; k++)
            send_pass(mk(0, 1'($urandom), 1'b0, 1'b0, 8'($urandom), $urandom));
        send_pass(mk(0, 0, 0, 1, 8'($urandom), $urandom));
    endtask

    // output held off while words keep coming, then a full pause
    task automatic test_backpressure;
        set_registers(32'd6, 32'd2, 8'd3);
        hold_left = 300;
        drive_traffic(60, 10);
        drain_status();
        drive_traffic(20, 10);
    endtask

    task automatic test_random_traffic(input logic [31:0] timeout, input logic [31:0] wait_ms,
                                       input logic [7:0] limit, input int n_items);
        set_registers(timeout, wait_ms, limit);
        drive_traffic(n_items, 15);
    endtask

    // output ready with random stalls and one long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each status word with the oldest expectation
    always @(posedge i_clk) begin : check_status
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_status++;
            if (status_q.size() == 0) begin
                report_mismatch("unexpected status word", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = status_q.pop_front();
                if (m_axis_tdata[2:0] !== want.mode)
                    report_mismatch("mode", 32'(m_axis_tdata[2:0]), 32'(want.mode));
                if (m_axis_tdata[3] !== want.is_connected)
                    report_mismatch("is_connected", 32'(m_axis_tdata[3]),
                                    32'(want.is_connected));
                if (m_axis_tdata[11:4] !== want.retries)
                    report_mismatch("retries", 32'(m_axis_tdata[11:4]), 32'(want.retries));
                if (m_axis_tdata[19:12] !== want.report_dbm)
                    report_mismatch("report_dbm", {24'd0, m_axis_tdata[19:12]},
                                    {24'd0, want.report_dbm});
                if (m_axis_tdata[51:20] !== want.report_address)
                    report_mismatch("report_address", m_axis_tdata[51:20],
                                    want.report_address);
                if (m_axis_tdata[52] !== want.begin_pulse)
                    report_mismatch("begin_pulse", 32'(m_axis_tdata[52]),
                                    32'(want.begin_pulse));
                if (m_axis_tdata[53] !== want.drop_pulse)
                    report_mismatch("drop_pulse", 32'(m_axis_tdata[53]),
                                    32'(want.drop_pulse));
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("run stopped by watchdog with %0d status words outstanding",
                 status_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_connect_sequence();
        test_zero_wait();
        test_retry_saturation();
        test_backpressure();
        test_random_traffic(32'd8, 32'd3, 8'd3, 100);
        test_random_traffic(32'd0, 32'd0, 8'd0, 180);
        test_random_traffic(32'd20, 32'd6, 8'd255, 100);
        test_random_traffic(32'd5, 32'd12, 8'd1, 180);
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2, 120);
        test_random_traffic($urandom_range(0, 12), $urandom_range(0, 12),
                            8'($urandom_range(0, 6)), 180);
        // last part without idling on either side
        drain_status();
        idle_on = 1'b0;
        test_random_traffic(32'd3, 32'd1, 8'd4, 150);

        drain_status();
        repeat (10) @(posedge i_clk);
        if (status_q.size() != 0)
            report_mismatch("status words never received", status_q.size(), 32'd0);

        $display("%0d loop passes sent, %0d status words checked, %0d register settings",
                 n_passes, n_status, n_settings);
        $display("covered mode walk, zero wait, retry ceiling, back-pressure, random traffic");
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/lcr_pkg.sv
rtl/lcr_cfg.sv
rtl/lcr_in_stage.sv
rtl/lcr_core.sv
rtl/link_connect_retry_fsm.sv
dv/tb_link_connect_retry_fsm.sv
